### rtl/assert_macros.svh
// assertion macros for the collision box table
// used by modules that check their own logic; expects clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CBT_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define CBT_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CBT_CHECK(label, ante, cons)
`define CBT_CHECK_NEXT(label, ante, cons)
`endif
`endif

### rtl/cbt_pkg.sv
// shared types and constants for the collision box table
// no dependencies
package cbt_pkg;

  localparam int MAX_BOXES_DEF = 32;
  localparam int SLOT_W = 5;
  localparam int COORD_W = 16;
  localparam int BYTE_W = 8;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

  typedef enum logic [2:0] {
    CMD_SET      = 3'd0,
    CMD_REG      = 3'd1,
    CMD_UNREG    = 3'd2,
    CMD_POINT    = 3'd3,
    CMD_FIND     = 3'd4,
    CMD_HIT      = 3'd5,
    CMD_AREA_DMG = 3'd6,
    CMD_READ     = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MODIFY,
    ST_SCAN,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x_a;
    logic [COORD_W-1:0] y_a;
    logic [COORD_W-1:0] x_b;
    logic [COORD_W-1:0] y_b;
    logic [BYTE_W-1:0]  box_width;
    logic [BYTE_W-1:0]  box_height;
    logic [BYTE_W-1:0]  kind;
    logic [BYTE_W-1:0]  damage_amount;
    logic [BYTE_W-1:0]  source_tag;
  } req_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [BYTE_W-1:0]  wide;
    logic [BYTE_W-1:0]  tall;
    logic [BYTE_W-1:0]  kind;
    logic [BYTE_W-1:0]  damage;
    logic [BYTE_W-1:0]  source;
  } box_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic modify;
    logic scan;
    logic reply;
  } ctl_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/cbt_if.sv
// request and response channel interfaces for the collision box table
// depends on cbt_pkg for field widths
interface cbt_req_if;
  import cbt_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [SLOT_W-1:0]  slot;
  logic [COORD_W-1:0] x_a;
  logic [COORD_W-1:0] y_a;
  logic [COORD_W-1:0] x_b;
  logic [COORD_W-1:0] y_b;
  logic [BYTE_W-1:0]  box_width;
  logic [BYTE_W-1:0]  box_height;
  logic [BYTE_W-1:0]  kind;
  logic [BYTE_W-1:0]  damage_amount;
  logic [BYTE_W-1:0]  source_tag;

  modport source (output valid, command, slot, x_a, y_a, x_b, y_b, box_width, box_height,
                  kind, damage_amount, source_tag, input ready);
  modport sink (input valid, command, slot, x_a, y_a, x_b, y_b, box_width, box_height,
                kind, damage_amount, source_tag, output ready);
endinterface

interface cbt_rsp_if;
  import cbt_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] found_slot;
  logic [BYTE_W-1:0] damage_value;
  logic [BYTE_W-1:0] source_value;

  modport source (output valid, found, found_slot, damage_value, source_value, input ready);
  modport sink (input valid, found, found_slot, damage_value, source_value, output ready);
endinterface

### rtl/cbt_ram.sv
// generic single write port ram with registered read
// no dependencies
module cbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/cbt_ctrl.sv
// command sequencer for the collision box table
// depends on cbt_pkg; drives the datapath through ctl_t and reads sts_t
module cbt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  cbt_pkg::cmd_t cmd,
  output logic          req_ready,
  output cbt_pkg::ctl_t ctl,
  input  cbt_pkg::sts_t sts
);
  import cbt_pkg::*;

  state_t state;
  state_t state_next;
  logic   is_scan;

  assign is_scan = (cmd == CMD_UNREG) || (cmd == CMD_POINT) || (cmd == CMD_FIND) ||
                   (cmd == CMD_AREA_DMG);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = is_scan ? ST_SCAN : ST_FETCH;
        end
      end
      ST_FETCH:  state_next = ST_MODIFY;
      ST_MODIFY: state_next = ST_REPLY;
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    ctl       = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        ctl.load  = req_valid;
      end
      ST_FETCH:  ctl.fetch  = 1'b1;
      ST_MODIFY: ctl.modify = 1'b1;
      ST_SCAN:   ctl.scan   = 1'b1;
      ST_REPLY:  ctl.reply  = sts.out_free;
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/cbt_dp.sv
// datapath of the collision box table: box and order rams, list walk, result register
// depends on cbt_pkg, cbt_ram, cbt_if and assert_macros.svh
`include "assert_macros.svh"
module cbt_dp #(
  parameter int MAX_BOXES = cbt_pkg::MAX_BOXES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cbt_pkg::ctl_t ctl,
  output cbt_pkg::sts_t sts,
  input  cbt_pkg::req_t req,
  cbt_rsp_if.source     response
);
  import cbt_pkg::*;

  localparam int SW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int BW = $bits(box_t);

  req_t             q;
  cmd_t             op;
  logic             ok;
  logic [SW-1:0]    slot_idx;
  logic [CW-1:0]    live_count;
  logic [MAX_BOXES-1:0] is_live;
  logic [MAX_BOXES-1:0] box_vld;
  logic             vld_q;

  logic             ord_we;
  logic [SW-1:0]    ord_waddr;
  logic [SW-1:0]    ord_wdata;
  logic [SW-1:0]    ord_raddr;
  logic [SW-1:0]    ord_rdata;

  logic             box_we;
  logic [SW-1:0]    box_waddr;
  box_t             box_wdata;
  logic [SW-1:0]    box_raddr;
  logic [BW-1:0]    box_rdata;
  box_t             cur;

  logic [CW-1:0]    idx;
  logic             p1_vld;
  logic [CW-1:0]    p1_idx;
  logic             p2_vld;
  logic [SW-1:0]    p2_slot;
  logic             shift;
  logic             issue;
  logic             active;
  logic             reg_ok;
  logic             scan_done;

  logic signed [16:0] l17, t17, r17, b17, cx, cy;
  logic signed [16:0] xa17, ya17, xb17, yb17;
  logic             point_hit;
  logic             centre_hit;
  logic             p2_match;
  logic             is_find;
  logic [8:0]       hit_sum;

  logic              res_found;
  logic [SLOT_W-1:0] res_slot;
  logic [BYTE_W-1:0] res_dmg;
  logic [BYTE_W-1:0] res_src;
  logic              out_vld;

  assign op       = cmd_t'(q.command);
  assign ok       = int'(q.slot) < MAX_BOXES;
  assign slot_idx = SW'(q.slot);
  assign active   = ok && is_live[slot_idx];
  assign reg_ok   = ok && !is_live[slot_idx] && (live_count < CW'(MAX_BOXES));
  assign is_find  = (op == CMD_POINT) || (op == CMD_FIND);

  cbt_ram #(.WIDTH(SW), .DEPTH(MAX_BOXES)) u_order (
    .clk     (clk),
    .wr_en   (ord_we),
    .wr_addr (ord_waddr),
    .wr_data (ord_wdata),
    .rd_addr (ord_raddr),
    .rd_data (ord_rdata)
  );

  cbt_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_box (
    .clk     (clk),
    .wr_en   (box_we),
    .wr_addr (box_waddr),
    .wr_data (box_wdata),
    .rd_addr (box_raddr),
    .rd_data (box_rdata)
  );

  // never-written slots read as zero
  assign cur = vld_q ? box_t'(box_rdata) : '0;

  // list walk: order read, then box read, then test
  assign issue     = ctl.scan && (idx < live_count);
  assign ord_raddr = idx[SW-1:0];
  assign box_raddr = ctl.fetch ? slot_idx : ord_rdata;

  assign l17  = $signed({cur.left[15], cur.left});
  assign t17  = $signed({cur.top[15], cur.top});
  assign r17  = l17 + $signed({9'b0, cur.wide});
  assign b17  = t17 + $signed({9'b0, cur.tall});
  assign cx   = l17 + $signed({10'b0, cur.wide[7:1]});
  assign cy   = t17 + $signed({10'b0, cur.tall[7:1]});
  assign xa17 = $signed({q.x_a[15], q.x_a});
  assign ya17 = $signed({q.y_a[15], q.y_a});
  assign xb17 = $signed({q.x_b[15], q.x_b});
  assign yb17 = $signed({q.y_b[15], q.y_b});

  assign point_hit  = (xa17 >= l17) && (xa17 < r17) && (ya17 >= t17) && (ya17 < b17) &&
                      (q.kind == cur.kind);
  assign centre_hit = (cur.kind == q.kind) && (cur.wide != '0) && (cx >= xa17) &&
                      (cx < xb17) && (cy >= ya17) && (cy < yb17);
  assign p2_match   = p2_vld && ((op == CMD_POINT) ? point_hit : centre_hit);

  assign scan_done = ctl.scan && ((!issue && !p1_vld && !p2_vld) || (is_find && p2_match));
  assign hit_sum   = {1'b0, cur.damage} + {1'b0, q.damage_amount};

  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = live_count[SW-1:0];
    ord_wdata = slot_idx;
    if (ctl.modify && op == CMD_REG && reg_ok) begin
      ord_we = 1'b1;
    end else if (ctl.scan && op == CMD_UNREG && p1_vld && shift) begin
      ord_we    = 1'b1;
      ord_waddr = SW'(p1_idx - CW'(1));
      ord_wdata = ord_rdata;
    end
  end

  always_comb begin
    box_we    = 1'b0;
    box_waddr = slot_idx;
    box_wdata = cur;
    if (ctl.modify) begin
      unique case (op)
        CMD_SET: begin
          box_we         = ok;
          box_wdata.left = q.x_a;
          box_wdata.top  = q.y_a;
          box_wdata.wide = q.box_width;
          box_wdata.tall = q.box_height;
          box_wdata.kind = q.kind;
        end
        CMD_REG: begin
          box_we           = reg_ok;
          box_wdata.wide   = '0;
          box_wdata.damage = '0;
        end
        CMD_HIT: begin
          box_we           = ok;
          box_wdata.damage = hit_sum[8] ? BYTE_MAX : hit_sum[7:0];
          box_wdata.source = q.source_tag;
        end
        default: box_we = 1'b0;
      endcase
    end else if (ctl.scan && op == CMD_AREA_DMG && p2_match) begin
      box_we           = 1'b1;
      box_waddr        = p2_slot;
      box_wdata.damage = hit_sum[7:0];
      box_wdata.source = q.source_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= req;
    end
    vld_q <= box_vld[box_raddr];
    p1_idx  <= idx;
    p2_slot <= ord_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      is_live    <= '0;
      box_vld    <= '0;
      idx        <= '0;
      p1_vld     <= 1'b0;
      p2_vld     <= 1'b0;
      shift      <= 1'b0;
    end else begin
      p1_vld <= issue;
      p2_vld <= ctl.scan && p1_vld;
      if (box_we) begin
        box_vld[box_waddr] <= 1'b1;
      end
      if (ctl.load) begin
        idx   <= '0;
        shift <= 1'b0;
      end else if (issue) begin
        idx <= idx + CW'(1);
      end
      if (ctl.scan && op == CMD_UNREG && p1_vld && active && ord_rdata == slot_idx) begin
        shift <= 1'b1;
      end
      if (ctl.modify && op == CMD_REG && reg_ok) begin
        live_count         <= live_count + CW'(1);
        is_live[slot_idx]  <= 1'b1;
      end
      if (scan_done && op == CMD_UNREG && active) begin
        live_count        <= live_count - CW'(1);
        is_live[slot_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_found <= 1'b0;
      res_slot  <= '0;
      res_dmg   <= '0;
      res_src   <= '0;
    end else if (ctl.modify && op == CMD_READ && ok) begin
      res_slot <= q.slot;
      res_dmg  <= cur.damage;
      res_src  <= cur.source;
    end else if (ctl.scan && is_find && p2_match) begin
      res_found <= 1'b1;
      res_slot  <= SLOT_W'(p2_slot);
    end
  end

  // output register parts the sequencer from the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (ctl.reply) begin
      out_vld <= 1'b1;
    end else if (response.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.reply) begin
      response.found        <= res_found;
      response.found_slot   <= res_slot;
      response.damage_value <= res_dmg;
      response.source_value <= res_src;
    end
  end

  assign response.valid = out_vld;
  assign sts.scan_done  = scan_done;
  assign sts.out_free   = !out_vld || response.ready;

  `CBT_CHECK(count_matches_live, 1'b1, $countones(is_live) == int'(live_count))
  `CBT_CHECK(count_bounded, 1'b1, live_count <= CW'(MAX_BOXES))
  `CBT_CHECK(walk_in_order, p2_vld, $past(p1_vld))

endmodule

### rtl/collision_box_table.sv
// collision box table: slot table of axis-aligned boxes with an ordered live list
// depends on cbt_pkg, cbt_if, cbt_ram, cbt_ctrl and cbt_dp
//
// request carries one command per transfer; response returns exactly one
// result transfer per command, in order. Commands are taken one at a time.
// Set, register, hit and read pass through the fetch, modify and reply states
// before the result appears on response. Point test, region find, unregister
// and region damage walk the live list one entry per cycle through the order
// ram and the box ram; point test and region find stop at their first match.
// The next request is taken in the idle state that follows the reply state,
// once the result is registered; the walk length, one list entry per cycle,
// sets how often list walks can run.
// A finished result sits in an output register, so the next request can be
// taken while the receiver stalls; a second result then waits until the
// first one is taken, and request stays not ready meanwhile.
// Reset clears the live list, the live flags and the written-slot flags;
// every box reads as zero until first written. No clearing pass is needed.
module collision_box_table #(
  parameter int MAX_BOXES = cbt_pkg::MAX_BOXES_DEF
) (
  input logic       clk,
  input logic       rst,
  cbt_req_if.sink   request,
  cbt_rsp_if.source response
);
  import cbt_pkg::*;

  ctl_t ctl;
  sts_t sts;
  req_t req;
  logic rdy;

  assign req = '{command: request.command, slot: request.slot, x_a: request.x_a,
                 y_a: request.y_a, x_b: request.x_b, y_b: request.y_b,
                 box_width: request.box_width, box_height: request.box_height,
                 kind: request.kind, damage_amount: request.damage_amount,
                 source_tag: request.source_tag};
  assign request.ready = rdy;

  cbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .cmd       (cmd_t'(request.command)),
    .req_ready (rdy),
    .ctl       (ctl),
    .sts       (sts)
  );

  cbt_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .req      (req),
    .response (response)
  );

endmodule

### test/cbt_test_pkg.sv
// stimulus row type for the collision box table testbench
// depends on cbt_pkg for field widths and the request type
package cbt_test_pkg;
  import cbt_pkg::*;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] found_slot;
    logic [BYTE_W-1:0] damage_value;
    logic [BYTE_W-1:0] source_value;
  } answer_t;

  typedef struct {
    req_t    cmd;
    bit      typed;
    answer_t answer;
  } row_t;
endpackage

### test/collision_box_table_test.sv
// testbench for collision_box_table: directed table then random command mix,
// each answer checked against a behavioral box table; random idling both sides
// depends on cbt_pkg, cbt_if, cbt_test_pkg and the rtl
module collision_box_table_test;
  import cbt_pkg::*;
  import cbt_test_pkg::*;

  localparam int NBOX = MAX_BOXES_DEF;
  localparam int N_RANDOM = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  cbt_req_if request ();
  cbt_rsp_if response ();

  collision_box_table uut (.clk(clk), .rst(rst), .request(request), .response(response));

  // predictor state
  logic [SLOT_W-1:0]  listed [NBOX];
  int                 listed_n;
  bit                 live [NBOX];
  logic signed [15:0] bx_left [NBOX];
  logic signed [15:0] bx_top [NBOX];
  logic [7:0]         bx_wide [NBOX], bx_tall [NBOX], bx_kind [NBOX];
  logic [7:0]         bx_damage [NBOX], bx_source [NBOX];

  answer_t expected_answers [$];
  int      errors = 0;
  bit      calm = 1'b0;
  bit      sending_done = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic bit centre_hit(int s, req_t c);
    logic signed [16:0] cx, cy;
    if (bx_kind[s] != c.kind || bx_wide[s] == 0) return 1'b0;
    cx = bx_left[s] + $signed({10'd0, bx_wide[s][7:1]});
    cy = bx_top[s] + $signed({10'd0, bx_tall[s][7:1]});
    return cx >= $signed(c.x_a) && cx < $signed(c.x_b) &&
           cy >= $signed(c.y_a) && cy < $signed(c.y_b);
  endfunction

  function automatic answer_t table_step(req_t c);
    answer_t a;
    int s;
    logic signed [16:0] px, py;
    logic [8:0] sum;
    a = '0;
    s = int'(c.slot);
    px = $signed(c.x_a);
    py = $signed(c.y_a);
    case (cmd_t'(c.command))
      CMD_SET: begin
        bx_left[s] = c.x_a; bx_top[s] = c.y_a;
        bx_wide[s] = c.box_width; bx_tall[s] = c.box_height; bx_kind[s] = c.kind;
      end
      CMD_REG: if (!live[s] && listed_n < NBOX) begin
        listed[listed_n] = c.slot; listed_n++;
        live[s] = 1'b1; bx_damage[s] = 0; bx_wide[s] = 0;
      end
      CMD_UNREG: if (live[s]) begin
        for (int i = 0; i < listed_n; i++) begin
          if (listed[i] == c.slot) begin
            for (int j = i; j + 1 < listed_n; j++) listed[j] = listed[j + 1];
            listed_n--;
            break;
          end
        end
        live[s] = 1'b0;
      end
      CMD_POINT: for (int i = 0; i < listed_n; i++) begin
        int b;
        b = int'(listed[i]);
        if (px >= bx_left[b] && px < bx_left[b] + $signed({9'd0, bx_wide[b]}) &&
            py >= bx_top[b] && py < bx_top[b] + $signed({9'd0, bx_tall[b]}) &&
            c.kind == bx_kind[b]) begin
          a.found = 1'b1; a.found_slot = SLOT_W'(b);
          break;
        end
      end
      CMD_FIND: for (int i = 0; i < listed_n; i++) begin
        if (centre_hit(int'(listed[i]), c)) begin
          a.found = 1'b1; a.found_slot = listed[i];
          break;
        end
      end
      CMD_HIT: begin
        sum = bx_damage[s] + c.damage_amount;
        bx_damage[s] = sum[8] ? BYTE_MAX : sum[7:0];
        bx_source[s] = c.source_tag;
      end
      CMD_AREA_DMG: for (int i = 0; i < listed_n; i++) begin
        int b;
        b = int'(listed[i]);
        if (centre_hit(b, c)) begin
          bx_damage[b] = bx_damage[b] + c.damage_amount;
          bx_source[b] = c.source_tag;
        end
      end
      default: begin
        a.found_slot = c.slot; a.damage_value = bx_damage[s]; a.source_value = bx_source[s];
      end
    endcase
    return a;
  endfunction

  function automatic req_t make_cmd(cmd_t op, int s, int xa, int ya, int xb, int yb,
                                    int w, int h, int k, int d, int src);
    req_t c;
    c.command = op; c.slot = SLOT_W'(s);
    c.x_a = COORD_W'(xa); c.y_a = COORD_W'(ya); c.x_b = COORD_W'(xb); c.y_b = COORD_W'(yb);
    c.box_width = BYTE_W'(w); c.box_height = BYTE_W'(h); c.kind = BYTE_W'(k);
    c.damage_amount = BYTE_W'(d);
    c.source_tag = BYTE_W'(src);
    return c;
  endfunction

  function automatic row_t plain(req_t c);
    row_t r;
    r.cmd = c; r.typed = 1'b0; r.answer = '0;
    return r;
  endfunction

  function automatic row_t typed(req_t c, answer_t a);
    row_t r;
    r.cmd = c; r.typed = 1'b1; r.answer = a;
    return r;
  endfunction

  function automatic req_t random_cmd();
    req_t c;
    int r;
    c = {$urandom, $urandom, $urandom, 16'($urandom)};
    // keep most coordinates near the boxes so queries hit
    if ($urandom_range(0, 3) != 0) begin
      c.x_a = COORD_W'(int'($urandom_range(0, 600)) - 300);
      c.y_a = COORD_W'(int'($urandom_range(0, 600)) - 300);
      c.x_b = COORD_W'(int'($signed(c.x_a)) + int'($urandom_range(0, 400)));
      c.y_b = COORD_W'(int'($signed(c.y_a)) + int'($urandom_range(0, 400)));
      c.kind = BYTE_W'($urandom_range(0, 3));
      c.box_width = $urandom_range(0, 3) == 0 ? BYTE_W'($urandom_range(0, 255)) :
                                                 BYTE_W'($urandom_range(1, 60));
    end
    r = $urandom_range(0, 99);
    c.command = r < 15 ? CMD_SET : r < 30 ? CMD_REG : r < 40 ? CMD_UNREG :
                r < 55 ? CMD_POINT : r < 68 ? CMD_FIND : r < 78 ? CMD_HIT :
                r < 86 ? CMD_AREA_DMG : CMD_READ;
    return c;
  endfunction

  function automatic bit idle_now();
    return !calm && $urandom_range(0, 99) < 26;
  endfunction

  task automatic send(req_t c);
    request.valid <= 1'b1;
    request.command <= c.command; request.slot <= c.slot;
    request.x_a <= c.x_a; request.y_a <= c.y_a; request.x_b <= c.x_b; request.y_b <= c.y_b;
    request.box_width <= c.box_width; request.box_height <= c.box_height;
    request.kind <= c.kind; request.damage_amount <= c.damage_amount;
    request.source_tag <= c.source_tag;
    do @(posedge clk); while (!request.ready);
    @(negedge clk);
  endtask

  task automatic push(row_t r);
    answer_t a;
    while (idle_now()) begin
      request.valid <= 1'b0;
      @(negedge clk);
    end
    a = table_step(r.cmd);
    if (r.typed && a != r.answer) report("typed row", a, r.answer);
    expected_answers.push_back(a);
    send(r.cmd);
  endtask

  initial begin
    row_t rows [$];
    answer_t z;
    z = '0;
    listed_n = 0;
    for (int i = 0; i < NBOX; i++) begin
      live[i] = 0; bx_left[i] = 0; bx_top[i] = 0; bx_wide[i] = 0; bx_tall[i] = 0;
      bx_kind[i] = 0; bx_damage[i] = 0; bx_source[i] = 0;
    end
    request.valid = 1'b0;
    {request.command, request.slot, request.x_a, request.y_a, request.x_b, request.y_b,
     request.box_width, request.box_height, request.kind, request.damage_amount,
     request.source_tag} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows.push_back(typed(make_cmd(CMD_READ, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0), '{0, 31, 0, 0}));
    rows.push_back(typed(make_cmd(CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), z));
    rows.push_back(typed(make_cmd(CMD_SET, 3, -32768, 32767, 0, 0, 255, 255, 255, 0, 0), z));
    rows.push_back(typed(make_cmd(CMD_REG, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), z));
    // registering a live slot changes nothing
    rows.push_back(typed(make_cmd(CMD_REG, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), z));
    // register cleared the width, so nothing is found
    rows.push_back(typed(make_cmd(CMD_POINT, 0, -32768, 32767, 0, 0, 0, 0, 255, 0, 0), z));
    rows.push_back(plain(make_cmd(CMD_SET, 3, 32767, -32768, 0, 0, 255, 255, 255, 0, 0)));
    rows.push_back(plain(make_cmd(CMD_FIND, 0, -32768, -32768, 32767, 32767, 0, 0, 255, 0,
                                  0)));
    rows.push_back(plain(make_cmd(CMD_SET, 3, 32767, -32768, 0, 0, 255, 255, 255, 0, 0)));
    rows.push_back(typed(make_cmd(CMD_POINT, 0, 32767, -32768, 0, 0, 0, 0, 255, 0, 0),
                         '{1, 3, 0, 0}));
    rows.push_back(typed(make_cmd(CMD_HIT, 3, 0, 0, 0, 0, 0, 0, 0, 200, 7), z));
    rows.push_back(typed(make_cmd(CMD_HIT, 3, 0, 0, 0, 0, 0, 0, 0, 200, 255), z));
    rows.push_back(typed(make_cmd(CMD_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), '{0, 3, 255, 255}));
    rows.push_back(plain(make_cmd(CMD_SET, 9, 0, 0, 0, 0, 10, 10, 255, 0, 0)));
    rows.push_back(plain(make_cmd(CMD_REG, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(plain(make_cmd(CMD_SET, 9, 0, 0, 0, 0, 10, 10, 255, 0, 0)));
    rows.push_back(plain(make_cmd(CMD_AREA_DMG, 0, -32768, -32768, 32767, 32767, 0, 0, 255,
                                  255, 1)));
    // region damage wraps
    rows.push_back(plain(make_cmd(CMD_AREA_DMG, 0, 0, 0, 6, 6, 0, 0, 255, 3, 2)));
    rows.push_back(plain(make_cmd(CMD_READ, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(typed(make_cmd(CMD_UNREG, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), z));
    rows.push_back(typed(make_cmd(CMD_UNREG, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), z));
    rows.push_back(plain(make_cmd(CMD_POINT, 0, 5, 5, 0, 0, 0, 0, 255, 0, 0)));
    rows.push_back(typed(make_cmd(CMD_HIT, 20, 0, 0, 0, 0, 0, 0, 0, 5, 9), z));
    rows.push_back(typed(make_cmd(CMD_READ, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0), '{0, 20, 5, 9}));
    foreach (rows[i]) push(rows[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = n >= 800 && n < 1100;
      push(plain(random_cmd()));
    end
    calm = 1'b0;
    request.valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    response.ready = 1'b0;
    @(negedge clk);
    forever begin
      response.ready <= !idle_now();
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && response.valid && response.ready) begin
      got = {response.found, response.found_slot, response.damage_value,
             response.source_value};
      if (expected_answers.size() == 0) begin
        report("unexpected transfer", got, 0);
      end else begin
        want = expected_answers.pop_front();
        if (got.found !== want.found) report("found", got.found, want.found);
        if (got.found_slot !== want.found_slot)
          report("found_slot", got.found_slot, want.found_slot);
        if (got.damage_value !== want.damage_value)
          report("damage_value", got.damage_value, want.damage_value);
        if (got.source_value !== want.source_value)
          report("source_value", got.source_value, want.source_value);
      end
    end
  end

  initial begin
    wait (sending_done);
    wait (expected_answers.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #10000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/cbt_pkg.sv
rtl/cbt_if.sv
rtl/cbt_ram.sv
rtl/cbt_ctrl.sv
rtl/cbt_dp.sv
rtl/collision_box_table.sv
test/cbt_test_pkg.sv
test/collision_box_table_test.sv
